@@ rtl/core/cdss_pkg.sv @@
// ----------------------------------------------------------------------------
// Clock divider source select package
// Widths and constants shared by the interfaces, the core and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package cdss_pkg;

    // Number of source rate registers held by the block.
    localparam int NumRegs = 8;
    // Width of a rate register, of a request and of the write data.
    localparam int RateW = 32;
    // Width of the register index on the write port (one spare bit so that
    // writes beyond the register list can be issued and ignored).
    localparam int CfgIdxW = 4;
    // Fraction bits of the divisor.
    localparam int FracBits = 12;
    // Width of the integer and fraction fields of the divisor.
    localparam int DivFieldW = 12;
    // Width of the source index field.
    localparam int SrcW = 3;
    // Width of the remembered source, wide enough to hold the auto code.
    localparam int SelW = 4;
    // Fraction bits of the achieved frequency.
    localparam int F8Bits = 8;
    // Dividend and quotient width of the shared divider.
    localparam int DivW = RateW + FracBits + F8Bits;
    // Width of the divider step counter.
    localparam int DivCntW = $clog2(DivW);
    // Width of the running error bound.
    localparam int ErrW = RateW + F8Bits;

    // Remembered source code that selects a scan over all sources.
    localparam logic [SelW-1:0] AutoSel = 4'd8;
    // Highest request that may use a fractional divisor.
    localparam logic [RateW-1:0] MaxFracRate = 32'd25000000;
    // Lower limit of the integer divisor.
    localparam logic [DivFieldW-1:0] DivMin = 12'd2;

endpackage

`default_nettype wire

@@ rtl/core/cdss_stream_if.sv @@
// ----------------------------------------------------------------------------
// Clock divider source select channels
// Valid/ready channels for rate requests and for divider settings.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel: one item is a requested output rate.
interface cdss_req_if;
    logic                          valid;
    logic                          ready;
    logic [cdss_pkg::RateW-1:0]    rate_hz;

    modport source (output valid, output rate_hz, input ready);
    modport sink   (input valid, input rate_hz, output ready);
endinterface

// Response channel: one item is a set of divider settings.
interface cdss_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              ok;
    logic [cdss_pkg::SrcW-1:0]         source_used;
    logic [cdss_pkg::DivFieldW-1:0]    div_int;
    logic [cdss_pkg::DivFieldW-1:0]    div_frac;
    logic                              mash_on;

    modport source (output valid, output ok, output source_used, output div_int,
                    output div_frac, output mash_on, input ready);
    modport sink   (input valid, input ok, input source_used, input div_int,
                    input div_frac, input mash_on, output ready);
endinterface

`default_nettype wire

@@ rtl/core/clock_divider_source_select.sv @@
// In auto mode an item scans every source and skips any that is unused, too
// slow or out of divisor range; a zero request goes straight to the result.
// Each divide runs on the single shared restoring divider. One item is in
// work at a time; the next is taken the cycle after its settings are
// registered, even while they wait.
// Reset clears the source rates to zero and returns the block to auto mode.
// ----------------------------------------------------------------------------
// Clock divider source select
// Picks a clock source and computes 12.12 fractional divider settings for a
// requested rate, using one shared bit-serial divider under a sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_divider_source_select #(
    parameter int NUM_SOURCES = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [cdss_pkg::CfgIdxW-1:0]     cfg_index,
    input  wire logic [cdss_pkg::RateW-1:0]       cfg_data,
    cdss_req_if.sink                              req,
    cdss_rsp_if.source                            rsp
);

    localparam int RateW    = cdss_pkg::RateW;
    localparam int DivW     = cdss_pkg::DivW;
    localparam int DivCntW  = cdss_pkg::DivCntW;
    localparam int ErrW     = cdss_pkg::ErrW;
    localparam int SrcW     = cdss_pkg::SrcW;
    localparam int SelW     = cdss_pkg::SelW;
    localparam int FracBits = cdss_pkg::FracBits;
    localparam int FieldW   = cdss_pkg::DivFieldW;
    localparam int F8Bits   = cdss_pkg::F8Bits;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_D1,
        S_R1,
        S_D2,
        S_ABS,
        S_CMP,
        S_FIN_START,
        S_FIN_D,
        S_FIN_R,
        S_DONE
    } state_t;

    // Control state.
    state_t                  state_reg, state_next;
    logic [SelW-1:0]         sel_reg, sel_next;
    logic [SelW-1:0]         idx_reg, idx_next;
    logic                    found_reg, found_next;
    logic [DivCntW-1:0]      cnt_reg, cnt_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    logic [RateW-1:0]        src_reg [cdss_pkg::NumRegs];

    // Payload and datapath state.
    logic [RateW-1:0]        rate_reg, rate_next;
    logic [ErrW-1:0]         best_reg, best_next;
    logic [SrcW-1:0]         best_idx_reg, best_idx_next;
    logic [DivW-1:0]         quo_reg, quo_next;
    logic [RateW-1:0]        rem_reg, rem_next;
    logic [RateW-1:0]        dvs_reg, dvs_next;
    logic [DivW-1:0]         diff_reg, diff_next;
    logic                    pend_ok_reg, pend_ok_next;
    logic [SrcW-1:0]         pend_src_reg, pend_src_next;
    logic [FieldW-1:0]       pend_int_reg, pend_int_next;
    logic [FieldW-1:0]       pend_frac_reg, pend_frac_next;
    logic                    rsp_ok_reg, rsp_ok_next;
    logic [SrcW-1:0]         rsp_src_reg, rsp_src_next;
    logic [FieldW-1:0]       rsp_int_reg, rsp_int_next;
    logic [FieldW-1:0]       rsp_frac_reg, rsp_frac_next;

    // Helper signals.
    logic [RateW-1:0]        src_rd;
    logic [RateW:0]          trial;
    logic                    trial_ge;
    logic                    d_in_range;
    logic [DivW-1:0]         want;
    logic                    in_take;
    logic                    out_free;
    logic                    auto_mode;

    // Source rate read at the scan index.
    assign src_rd = src_reg[idx_reg[SrcW-1:0]];

    // One restoring divide step: shift in the next dividend bit and try.
    assign trial    = {rem_reg, quo_reg[DivW-1]};
    assign trial_ge = (trial >= {1'b0, dvs_reg});

    // Integer divisor range check on a finished 12.12 quotient.
    assign d_in_range = (quo_reg[DivW-1:FracBits+FieldW] == '0) &&
                        (quo_reg[FracBits+FieldW-1:FracBits] >= cdss_pkg::DivMin);

    // Request scaled to the achieved-frequency fraction bits.
    assign want = {{(DivW-ErrW){1'b0}}, rate_reg, {F8Bits{1'b0}}};

    assign in_take   = req.valid && (state_reg == S_IDLE);
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign auto_mode = (sel_reg >= SelW'(NUM_SOURCES));

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.ok          = rsp_ok_reg;
    assign rsp.source_used = rsp_src_reg;
    assign rsp.div_int     = rsp_int_reg;
    assign rsp.div_frac    = rsp_frac_reg;
    assign rsp.mash_on     = (rsp_frac_reg != '0);

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg;
        rate_next      = rate_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        diff_next      = diff_reg;
        pend_ok_next   = pend_ok_reg;
        pend_src_next  = pend_src_reg;
        pend_int_next  = pend_int_reg;
        pend_frac_next = pend_frac_reg;
        rsp_ok_next    = rsp_ok_reg;
        rsp_src_next   = rsp_src_reg;
        rsp_int_next   = rsp_int_reg;
        rsp_frac_next  = rsp_frac_reg;

        // The response register empties when the item is taken.
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    rate_next      = req.rate_hz;
                    pend_ok_next   = 1'b0;
                    pend_src_next  = '0;
                    pend_int_next  = '0;
                    pend_frac_next = '0;
                    if (req.rate_hz == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else if (auto_mode)
                    begin
                        idx_next   = '0;
                        found_next = 1'b0;
                        best_next  = {req.rate_hz, {F8Bits{1'b0}}};
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        idx_next   = sel_reg;
                        state_next = S_FIN_START;
                    end
                end
            end

            // Pick the next source to try, or close the scan.
            S_SCAN:
            begin
                if (idx_reg == SelW'(NUM_SOURCES))
                begin
                    if (found_reg)
                    begin
                        sel_next   = {1'b0, best_idx_reg};
                        idx_next   = {1'b0, best_idx_reg};
                        state_next = S_FIN_START;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (src_rd == '0 || src_rd < rate_reg)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    quo_next   = {{(DivW-RateW-FracBits){1'b0}}, src_rd, {FracBits{1'b0}}};
                    rem_next   = '0;
                    dvs_next   = rate_reg;
                    cnt_next   = DivCntW'(DivW - 1);
                    state_next = S_D1;
                end
            end

            S_D1, S_D2, S_FIN_D:
            begin
                rem_next = trial_ge ? RateW'(trial - {1'b0, dvs_reg}) : trial[RateW-1:0];
                quo_next = {quo_reg[DivW-2:0], trial_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    priority case (state_reg)
                        S_D1:    state_next = S_R1;
                        S_D2:    state_next = S_ABS;
                        default: state_next = S_FIN_R;
                    endcase
                end
            end

            // Divisor known: skip the source or divide again for its rate.
            S_R1:
            begin
                if (!d_in_range)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN;
                end
                else
                begin
                    dvs_next   = quo_reg[RateW-1:0];
                    quo_next   = {src_rd, {(DivW-RateW){1'b0}}};
                    rem_next   = '0;
                    cnt_next   = DivCntW'(DivW - 1);
                    state_next = S_D2;
                end
            end

            // Distance of the achieved rate from the request.
            S_ABS:
            begin
                diff_next  = (quo_reg >= want) ? (quo_reg - want) : (want - quo_reg);
                state_next = S_CMP;
            end

            // Keep the source only when it is strictly closer.
            S_CMP:
            begin
                if (diff_reg < {{(DivW-ErrW){1'b0}}, best_reg})
                begin
                    best_next     = diff_reg[ErrW-1:0];
                    best_idx_next = idx_reg[SrcW-1:0];
                    found_next    = 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_SCAN;
            end

            S_FIN_START:
            begin
                quo_next   = {{(DivW-RateW-FracBits){1'b0}}, src_rd, {FracBits{1'b0}}};
                rem_next   = '0;
                dvs_next   = rate_reg;
                cnt_next   = DivCntW'(DivW - 1);
                state_next = S_FIN_D;
            end

            // Final checks on the remembered source.
            S_FIN_R:
            begin
                if (d_in_range && !(quo_reg[FracBits-1:0] != '0 &&
                                    rate_reg > cdss_pkg::MaxFracRate))
                begin
                    pend_ok_next   = 1'b1;
                    pend_src_next  = sel_reg[SrcW-1:0];
                    pend_int_next  = quo_reg[FracBits+FieldW-1:FracBits];
                    pend_frac_next = quo_reg[FracBits-1:0];
                end
                state_next = S_DONE;
            end

            // Hand the settings to the response register when it is free.
            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_ok_next    = pend_ok_reg;
                    rsp_src_next   = pend_src_reg;
                    rsp_int_next   = pend_int_reg;
                    rsp_frac_next  = pend_frac_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers and source rate registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= cdss_pkg::AutoSel;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < cdss_pkg::NumRegs; i++)
            begin
                src_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we && !cfg_index[cdss_pkg::CfgIdxW-1])
            begin
                src_reg[cfg_index[SrcW-1:0]] <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rate_reg      <= rate_next;
        best_reg      <= best_next;
        best_idx_reg  <= best_idx_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        dvs_reg       <= dvs_next;
        diff_reg      <= diff_next;
        pend_ok_reg   <= pend_ok_next;
        pend_src_reg  <= pend_src_next;
        pend_int_reg  <= pend_int_next;
        pend_frac_reg <= pend_frac_next;
        rsp_ok_reg    <= rsp_ok_next;
        rsp_src_reg   <= rsp_src_next;
        rsp_int_reg   <= rsp_int_next;
        rsp_frac_reg  <= rsp_frac_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/cdss_checker.sv @@
// ----------------------------------------------------------------------------
// Clock divider source select checker
// Port-level assertions on the request and response channels.
// ----------------------------------------------------------------------------
`default_nettype none

module cdss_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             req_valid,
    input wire logic                             req_ready,
    input wire logic                             rsp_valid,
    input wire logic                             rsp_ready,
    input wire logic                             ok,
    input wire logic [cdss_pkg::SrcW-1:0]        source_used,
    input wire logic [cdss_pkg::DivFieldW-1:0]   div_int,
    input wire logic [cdss_pkg::DivFieldW-1:0]   div_frac,
    input wire logic                             mash_on
);

    // A failed item carries all-zero settings.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !ok) |-> (source_used == '0 && div_int == '0 &&
                                div_frac == '0 && !mash_on))
        else $error("failed item carries nonzero settings");

    // A good item has an integer divisor of at least two.
    a_int_min: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && ok) |-> (div_int >= cdss_pkg::DivMin))
        else $error("integer divisor below two");

    // MASH is on exactly when the fraction is nonzero.
    a_mash: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && ok) |-> (mash_on == (div_frac != '0)))
        else $error("MASH enable does not match fraction");

    // The block is busy in the cycle after taking an item.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken back to back");

    // A stalled response holds its settings.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(ok) &&
            $stable(source_used) && $stable(div_int) && $stable(div_frac)))
        else $error("stalled response changed");

endmodule

bind clock_divider_source_select cdss_checker u_cdss_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .ok          (rsp.ok),
    .source_used (rsp.source_used),
    .div_int     (rsp.div_int),
    .div_frac    (rsp.div_frac),
    .mash_on     (rsp.mash_on)
);

`default_nettype wire

@@ tb/cdss_settings_check.sv @@
// ----------------------------------------------------------------------------
// Clock divider source select: settings checker
// Watches the register port and both channels. Keeps its own copy of the
// source rates and of the remembered source, predicts the divider settings
// for every accepted request and compares each returned item field by field.
// ----------------------------------------------------------------------------
module cdss_settings_check (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [cdss_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [cdss_pkg::RateW-1:0]     cfg_data,
    cdss_req_if                                 req,
    cdss_rsp_if                                 rsp,
    output int                                  errors,
    output int                                  pending,
    output int                                  settings_seen,
    output int                                  settings_ok,
    output int                                  mash_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import cdss_pkg::*;

    typedef struct packed {
        logic                   ok;
        logic [SrcW-1:0]        source_used;
        logic [DivFieldW-1:0]   div_int;
        logic [DivFieldW-1:0]   div_frac;
        logic                   mash_on;
    } div_settings_t;

    // Mirror of the block's registers and remembered source.
    logic [RateW-1:0]   source_rate [NumRegs];
    logic [SelW-1:0]    remembered;

    // Settings still owed by the block, with the rate that asked for them.
    div_settings_t      settings_due_q [$];
    logic [RateW-1:0]   rate_due_q [$];
    logic [RateW-1:0]   cur_rate;

    task automatic flag_error(input string msg);
        $display("%0t ERROR %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_field(input string field, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v)
            flag_error($sformatf("item %0d, rate %0d Hz: %s expected %0d, got %0d",
                                 settings_seen, cur_rate, field, exp_v, got_v));
    endtask

    // Integer part of a 12.12 divisor must lie in 2..4095.
    function automatic bit int_part_ok(input logic [63:0] dvsr);
        logic [63:0] q;
        q = dvsr >> FracBits;
        return q >= 64'(DivMin) && q <= 64'((1 << DivFieldW) - 1);
    endfunction

    // Divider settings for one request; may latch the remembered source.
    function automatic div_settings_t predict_settings(input logic [RateW-1:0] rate);
        div_settings_t res;
        logic [63:0] want, best, dvsr, f8, err;
        res = '0;
        if (rate == '0)
            return res;

        // Auto mode: keep the source whose achieved rate is strictly closest.
        if (remembered >= NumRegs) begin
            want = 64'(rate) << F8Bits;
            best = want;
            for (int i = 0; i < NumRegs; i++) begin
                if (source_rate[i] == '0 || source_rate[i] < rate)
                    continue;
                dvsr = (64'(source_rate[i]) << FracBits) / 64'(rate);
                if (!int_part_ok(dvsr))
                    continue;
                f8 = (64'(source_rate[i]) << (FracBits + F8Bits)) / dvsr;
                err = (f8 > want) ? f8 - want : want - f8;
                if (err < best) begin
                    best = err;
                    remembered = SelW'(i);
                end
            end
            if (remembered >= NumRegs)
                return res;
        end

        // Final divisor for the remembered source.
        dvsr = (64'(source_rate[remembered[SrcW-1:0]]) << FracBits) / 64'(rate);
        if (dvsr[FracBits-1:0] != '0 && rate > MaxFracRate)
            return res;
        if (!int_part_ok(dvsr))
            return res;
        res.ok = 1'b1;
        res.source_used = remembered[SrcW-1:0];
        res.div_int = dvsr[FracBits+DivFieldW-1:FracBits];
        res.div_frac = dvsr[FracBits-1:0];
        res.mash_on = |dvsr[FracBits-1:0];
        return res;
    endfunction

    // Track writes, predict on each accepted request, compare each result.
    always @(posedge clk or negedge rst_n) begin
        div_settings_t due;
        if (!rst_n) begin
            for (int i = 0; i < NumRegs; i++)
                source_rate[i] = '0;
            remembered = AutoSel;
            settings_due_q.delete();
            rate_due_q.delete();
            errors = 0;
            pending = 0;
            settings_seen = 0;
            settings_ok = 0;
            mash_seen = 0;
        end
        else begin
            if (cfg_we && cfg_index < NumRegs)
                source_rate[cfg_index[SrcW-1:0]] = cfg_data;
            if (req.valid && req.ready) begin
                settings_due_q.push_back(predict_settings(req.rate_hz));
                rate_due_q.push_back(req.rate_hz);
            end
            if (rsp.valid && rsp.ready) begin
                if (settings_due_q.size() == 0) begin
                    flag_error("settings item returned with no request outstanding");
                end
                else begin
                    due = settings_due_q.pop_front();
                    cur_rate = rate_due_q.pop_front();
                    check_field("ok", 32'(due.ok), 32'(rsp.ok));
                    check_field("source_used", 32'(due.source_used), 32'(rsp.source_used));
                    check_field("div_int", 32'(due.div_int), 32'(rsp.div_int));
                    check_field("div_frac", 32'(due.div_frac), 32'(rsp.div_frac));
                    check_field("mash_on", 32'(due.mash_on), 32'(rsp.mash_on));
                    settings_seen++;
                    if (due.ok)
                        settings_ok++;
                    if (due.mash_on)
                        mash_seen++;
                end
            end
            pending = settings_due_q.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Clock divider source select: testbench top
// Drives rate requests and source-rate writes into the block, stalls the
// response channel at random, and gives the verdict from the checker's count.
// Auto scans that find nothing run over several source sets first; one scan
// then selects a source, and the remaining phases vary that source's rate.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cdss_pkg::*;

    localparam int QuietLimit = 10000;
    localparam int TailCycles = 1000;
    localparam int KeptSrc = 4;
    localparam int BadIdxLow = NumRegs;
    localparam int BadIdxHigh = (1 << CfgIdxW) - 1;
    localparam int MissPhases = 3;
    localparam int MissItems = 40;
    localparam int KeptItems = 80;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CfgIdxW-1:0]     cfg_index;
    logic [RateW-1:0]       cfg_data;

    cdss_req_if req_ch ();
    cdss_rsp_if rsp_ch ();

    int errors, pending, settings_seen, settings_ok, mash_seen;
    int items_sent, rate_settings, quiet, stall_left, stall_n;
    bit steady;
    logic [RateW-1:0] src_cfg [NumRegs];

    clock_divider_source_select dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    cdss_settings_check u_settings_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .errors        (errors),
        .pending       (pending),
        .settings_seen (settings_seen),
        .settings_ok   (settings_ok),
        .mash_seen     (mash_seen)
    );

    always #5ns clk = ~clk;

    // Idle length: mostly none, some short, a few long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Random source rate, weighted toward unused and extreme values.
    function automatic logic [RateW-1:0] rand_source_rate();
        case ($urandom_range(0, 7))
            0, 1: return '0;
            2: return '1;
            3: return $urandom_range(1, 8191);
            default: return $urandom;
        endcase
    endfunction

    // A request that no loaded source can serve: above half the fastest
    // source, or so low that every divisor overflows 12 bits.
    function automatic logic [RateW-1:0] scan_miss_rate();
        logic [RateW-1:0] fastest, low_cap;
        bit any;
        fastest = '0;
        low_cap = '1;
        any = 0;
        for (int i = 0; i < NumRegs; i++) begin
            if (src_cfg[i] != '0) begin
                any = 1;
                if (src_cfg[i] > fastest)
                    fastest = src_cfg[i];
                if ((src_cfg[i] >> FracBits) < low_cap)
                    low_cap = src_cfg[i] >> FracBits;
            end
        end
        if (!any)
            return $urandom;
        if ($urandom_range(0, 9) == 0)
            return '0;
        if (low_cap != '0 && $urandom_range(0, 2) == 0)
            return $urandom_range(1, low_cap);
        return $urandom_range((fastest >> 1) + 1, 32'hFFFF_FFFF);
    endfunction

    // A request aimed at the remembered source: mostly inside the usable
    // divisor range, with boundaries, exact divisors and noise mixed in.
    function automatic logic [RateW-1:0] pick_rate(input logic [RateW-1:0] s);
        logic [RateW-1:0] lo, hi, q;
        int unsigned k;
        lo = s / 4095;
        if (lo == '0)
            lo = 1;
        hi = s / 2;
        if (hi < lo)
            hi = lo;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return ($urandom_range(0, 1) != 0) ? 32'd0 : 32'd1;
            5: return $urandom_range(1, MaxFracRate);
            6:
            begin
                k = $urandom_range(2, 16);
                q = s / k;
                return (q == '0) ? 32'd1 : q;
            end
            7:
            begin
                case ($urandom_range(0, 5))
                    0: q = s / 2;
                    1: q = s / 2 + 1;
                    2: q = lo;
                    3: q = s >> FracBits;
                    4: q = MaxFracRate;
                    default: q = MaxFracRate + 1;
                endcase
                return (q == '0) ? 32'd1 : q;
            end
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    // One register write; starts and ends at a falling edge.
    task automatic cfg_write(input int idx, input logic [RateW-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= CfgIdxW'(idx);
        cfg_data <= val;
        if (idx < NumRegs)
            src_cfg[idx] = val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_sources(input logic [RateW-1:0] rates [NumRegs]);
        for (int i = 0; i < NumRegs; i++)
            cfg_write(i, rates[i]);
        rate_settings++;
    endtask

    // Offer one request and hold it until the block takes it.
    task automatic send_rate(input logic [RateW-1:0] rate);
        int gap;
        gap = steady ? 0 : idle_len();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.rate_hz <= rate;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every owed settings item has come back.
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // Response side: random stalls unless a steady stretch is running.
    always @(negedge clk) begin
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
        end
        else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
        end
        else begin
            stall_n = steady ? 0 : idle_len();
            rsp_ch.ready <= (stall_n == 0);
            stall_left = (stall_n > 0) ? stall_n - 1 : 0;
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                quiet = 0;
            end
            else if (quiet >= QuietLimit) begin
                $display("Watchdog: no item moved for %0d cycles, %0d still owed",
                         quiet, pending);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else begin
                quiet++;
            end
        end
    end

    initial begin
        logic [RateW-1:0] kept_plan [6];
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.rate_hz = '0;
        rsp_ch.ready = 1'b0;
        steady = 1;
        quiet = 0;
        stall_left = 0;
        items_sent = 0;
        rate_settings = 0;
        for (int i = 0; i < NumRegs; i++)
            src_cfg[i] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Nothing loaded: every scan is empty and a zero request is refused.
        send_rate('0);
        send_rate(32'd1);
        send_rate('1);
        send_rate(MaxFracRate);
        settle();

        // Writes beyond the register list must leave the sources unused.
        cfg_write(BadIdxLow, 32'd50_000_000);
        cfg_write(BadIdxHigh, '1);
        send_rate(32'd1_000_000);
        settle();

        // Extreme rates loaded; requests too fast or too slow for all of them.
        load_sources('{'1, 32'd1, '0, 32'd54_000_000, 32'd500_000_000,
                       32'h8000_0000, 32'd4096, 32'd19_200_000});
        send_rate(32'h8000_0000);
        send_rate(32'd1);
        settle();

        // Random source sets with requests that no source can serve.
        repeat (MissPhases) begin
            for (int i = 0; i < NumRegs; i++)
                cfg_write(i, rand_source_rate());
            rate_settings++;
            for (int n = 0; n < MissItems; n++) begin
                if (n % 20 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                send_rate(scan_miss_rate());
            end
            settle();
        end
        steady = 1;

        // The selecting scan skips unused, too slow and out-of-range sources,
        // breaks a tie toward the lower index, and keeps its choice although
        // the fraction above 25 MHz makes that first answer fail.
        load_sources('{'0, 32'd20_000_000, 32'd15_000_000, 32'd61_000_000,
                       32'd100_000_000, 32'd100_000_000, 32'd45_000_000, '0});
        send_rate('1);
        send_rate(32'd30_000_000);
        send_rate('0);
        send_rate(MaxFracRate);
        send_rate(MaxFracRate - 1);
        send_rate(32'd50_000_000);
        send_rate(32'd50_000_001);
        send_rate(32'd24_414);
        send_rate(32'd24_420);
        settle();

        // Remembered source at several rates, zero and tiny among them; the
        // other registers are scrambled once to show they no longer matter.
        kept_plan = '{'1, 32'd250_000_000, $urandom, 32'd3, '0, 32'd100_000_000};
        for (int p = 0; p < 6; p++) begin
            cfg_write(KeptSrc, kept_plan[p]);
            if (p == 2) begin
                for (int i = 0; i < NumRegs; i++)
                    if (i != KeptSrc)
                        cfg_write(i, $urandom);
            end
            rate_settings++;
            for (int n = 0; n < KeptItems; n++) begin
                if (n % 20 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                send_rate(pick_rate(src_cfg[KeptSrc]));
            end
            settle();
        end

        // Let any stray item surface before the verdict.
        repeat (TailCycles) @(negedge clk);
        $display("Run covered %0d requests over %0d source-rate settings in auto and remembered mode.",
                 items_sent, rate_settings);
        $display("%0d settings items checked: %0d valid, %0d with MASH on, %0d mismatches.",
                 settings_seen, settings_ok, mash_seen, errors);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/cdss_pkg.sv
rtl/core/cdss_stream_if.sv
rtl/core/clock_divider_source_select.sv
rtl/core/cdss_checker.sv
tb/cdss_settings_check.sv
tb/tb_top.sv
